// File: rtl/fmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmb_pkg;

    localparam logic [2:0] KIND_ALPHA    = 3'd0;
    localparam logic [2:0] KIND_BETA     = 3'd1;
    localparam logic [2:0] KIND_KINETIC  = 3'd2;
    localparam logic [2:0] KIND_NUCLEAR  = 3'd3;
    localparam logic [2:0] KIND_INTEGRAL = 3'd4;
    localparam logic [2:0] KIND_FINISH   = 3'd5;

    typedef struct packed {
        logic       load_we;
        logic       capture;
        logic       fin_start;
        logic       fin_rd;
        logic       int_mul;
        logic       int_acc;
        logic       fin_mul;
        logic       fin_sum;
        logic       fin_acc;
        logic       fin_en1;
        logic       fin_en2;
        logic       acc_clear;
        logic [2:0] row;
        logic [2:0] col;
        logic       last;
    } fmb_cmd_t;

    // Q.16 product of two narrow values, rounded half away from zero
    function automatic logic signed [33:0] mul_small(input logic signed [24:0] a,
                                                     input logic signed [23:0] b);
        logic [24:0] ma;
        logic [23:0] mb;
        logic [48:0] p;
        logic [33:0] r;
        ma = a[24] ? 25'(-a) : 25'(a);
        mb = b[23] ? 24'(-b) : 24'(b);
        p  = 49'(ma) * 49'(mb);
        r  = 34'((p + 49'd32768) >> 16);
        return (a[24] ^ b[23]) ? -$signed(r) : $signed(r);
    endfunction

    // combines the split partial products of a wide Q.16 product
    function automatic logic signed [63:0] big_round(input logic [48:0] hp,
                                                     input logic [56:0] lp,
                                                     input logic neg);
        logic [63:0] r;
        if (hp >= 49'h4000_0000_0000)
        begin
            r = 64'h4000_0000_0000_0000;
        end
        else
        begin
            r = (64'(hp) << 16) + 64'((lp + 57'd32768) >> 16);
            if (r > 64'h4000_0000_0000_0000)
            begin
                r = 64'h4000_0000_0000_0000;
            end
        end
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] half_round(input logic signed [63:0] x);
        logic [63:0] ux;
        logic [63:0] r;
        ux = x[63] ? 64'(-x) : 64'(x);
        r  = (ux >> 1) + 64'(ux[0]);
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [55:0] sat56(input logic signed [56:0] x);
        if (x[56] != x[55])
        begin
            return x[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
        end
        return x[55:0];
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [64:0] x);
        if (x[64] != x[63])
        begin
            return x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return x[63:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [57:0] x);
        if (x > 58'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -58'sh8000_0000)
        begin
            return -32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [64:0] x);
        if (x > 65'sh7FFF_FFFF_FFFF)
        begin
            return 48'sh7FFF_FFFF_FFFF;
        end
        if (x < -65'sh8000_0000_0000)
        begin
            return -48'sh8000_0000_0000;
        end
        return x[47:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/fmb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fmb_datapath import fmb_pkg::*; #(
    parameter int BASIS_MAX = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fmb_cmd_t            cmd,
    input  wire logic [2:0]          kind,
    input  wire logic [2:0]          index_i,
    input  wire logic [2:0]          index_j,
    input  wire logic [2:0]          index_k,
    input  wire logic [2:0]          index_l,
    input  wire logic signed [23:0]  value,
    output logic signed [31:0]       fock_element,
    output logic [2:0]               row,
    output logic [2:0]               col,
    output logic                     last,
    output logic signed [47:0]       kinetic_energy,
    output logic signed [47:0]       energy_nuclear,
    output logic signed [47:0]       coulomb_energy,
    output logic signed [47:0]       exchange_energy,
    output logic signed [47:0]       total_energy
);

    localparam int DEPTH = BASIS_MAX * BASIS_MAX;
    localparam int AW    = $clog2(DEPTH);

    logic signed [23:0] alpha_mem [DEPTH];
    logic signed [23:0] beta_mem  [DEPTH];
    logic signed [23:0] kin_mem   [DEPTH];
    logic signed [23:0] nuc_mem   [DEPTH];
    logic signed [55:0] j_mem     [DEPTH];
    logic signed [55:0] ka_mem    [DEPTH];
    logic signed [55:0] kb_mem    [DEPTH];
    logic [DEPTH-1:0]   j_vld_reg;
    logic [DEPTH-1:0]   ka_vld_reg;
    logic [DEPTH-1:0]   kb_vld_reg;

    logic [2:0]         int_i_reg, int_j_reg, int_k_reg, int_l_reg;
    logic signed [23:0] int_v_reg;

    logic [AW-1:0] addr_load, addr_kl, addr_jk, addr_ij, addr_il, addr_rc, addr_cr;
    logic [AW-1:0] addr_a, addr_m, addr_x;

    logic signed [23:0] a_rd_a_reg, a_rd_b_reg, b_rd_a_reg, b_rd_b_reg;
    logic signed [23:0] t_rd_reg, v_rd_reg;
    logic signed [55:0] j_rd_reg, ka_rd_reg, kb_rd_reg;
    logic               j_vrd_reg, ka_vrd_reg, kb_vrd_reg;
    logic signed [55:0] j_eff, ka_eff, kb_eff;

    logic signed [33:0] pj_reg, pa_reg, pb_reg;
    logic signed [24:0] pt, ptc;

    logic [24:0]        ub_t;
    logic [23:0]        ub_a, ub_b;
    logic [55:0]        uj, uka, ukb;
    logic [48:0]        hp_j_reg, hp_a_reg, hp_b_reg;
    logic [56:0]        lp_j_reg, lp_a_reg, lp_b_reg;
    logic               neg_j_reg, neg_a_reg, neg_b_reg;
    logic signed [33:0] tk_reg, tv_reg;
    logic signed [31:0] f_reg;

    logic signed [63:0] qk_reg, qv_reg, qj_reg, qa_reg, qb_reg;
    logic signed [63:0] tr_k_reg, tr_v_reg, tr_j_reg, tr_a_reg, tr_b_reg;
    logic signed [47:0] ek_reg, ev_reg, ec_reg, ex_reg;

    assign addr_load = AW'(32'(index_i) * BASIS_MAX + 32'(index_j));
    assign addr_kl   = AW'(32'(int_k_reg) * BASIS_MAX + 32'(int_l_reg));
    assign addr_jk   = AW'(32'(int_j_reg) * BASIS_MAX + 32'(int_k_reg));
    assign addr_ij   = AW'(32'(int_i_reg) * BASIS_MAX + 32'(int_j_reg));
    assign addr_il   = AW'(32'(int_i_reg) * BASIS_MAX + 32'(int_l_reg));
    assign addr_rc   = AW'(32'(cmd.row) * BASIS_MAX + 32'(cmd.col));
    assign addr_cr   = AW'(32'(cmd.col) * BASIS_MAX + 32'(cmd.row));
    assign addr_a    = cmd.fin_rd ? addr_cr : addr_kl;
    assign addr_m    = cmd.fin_rd ? addr_rc : addr_ij;
    assign addr_x    = cmd.fin_rd ? addr_rc : addr_il;

    assign j_eff  = j_vrd_reg  ? j_rd_reg  : '0;
    assign ka_eff = ka_vrd_reg ? ka_rd_reg : '0;
    assign kb_eff = kb_vrd_reg ? kb_rd_reg : '0;

    assign pt  = 25'(a_rd_a_reg) + 25'(b_rd_a_reg);
    assign ptc = pt;

    assign ub_t = ptc[24] ? 25'(-ptc) : 25'(ptc);
    assign ub_a = a_rd_a_reg[23] ? 24'(-a_rd_a_reg) : 24'(a_rd_a_reg);
    assign ub_b = b_rd_a_reg[23] ? 24'(-b_rd_a_reg) : 24'(b_rd_a_reg);
    assign uj   = j_eff[55]  ? 56'(-j_eff)  : 56'(j_eff);
    assign uka  = ka_eff[55] ? 56'(-ka_eff) : 56'(ka_eff);
    assign ukb  = kb_eff[55] ? 56'(-kb_eff) : 56'(kb_eff);

    // input matrices
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            case (kind)
                KIND_ALPHA:   alpha_mem[addr_load] <= value;
                KIND_BETA:    beta_mem[addr_load]  <= value;
                KIND_KINETIC: kin_mem[addr_load]   <= value;
                KIND_NUCLEAR: nuc_mem[addr_load]   <= value;
                default:      ;
            endcase
        end
        a_rd_a_reg <= alpha_mem[addr_a];
        a_rd_b_reg <= alpha_mem[addr_jk];
        b_rd_a_reg <= beta_mem[addr_a];
        b_rd_b_reg <= beta_mem[addr_jk];
        t_rd_reg   <= kin_mem[addr_m];
        v_rd_reg   <= nuc_mem[addr_m];
    end

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.int_acc)
        begin
            j_mem[addr_ij]  <= sat56(57'(j_eff) + 57'(pj_reg));
            ka_mem[addr_il] <= sat56(57'(ka_eff) + 57'(pa_reg));
            kb_mem[addr_il] <= sat56(57'(kb_eff) + 57'(pb_reg));
        end
        j_rd_reg  <= j_mem[addr_m];
        ka_rd_reg <= ka_mem[addr_x];
        kb_rd_reg <= kb_mem[addr_x];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_vld_reg  <= '0;
            ka_vld_reg <= '0;
            kb_vld_reg <= '0;
            j_vrd_reg  <= 1'b0;
            ka_vrd_reg <= 1'b0;
            kb_vrd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_clear)
            begin
                j_vld_reg  <= '0;
                ka_vld_reg <= '0;
                kb_vld_reg <= '0;
            end
            else if (cmd.int_acc)
            begin
                j_vld_reg[addr_ij]  <= 1'b1;
                ka_vld_reg[addr_il] <= 1'b1;
                kb_vld_reg[addr_il] <= 1'b1;
            end
            j_vrd_reg  <= j_vld_reg[addr_m];
            ka_vrd_reg <= ka_vld_reg[addr_x];
            kb_vrd_reg <= kb_vld_reg[addr_x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            int_i_reg <= index_i;
            int_j_reg <= index_j;
            int_k_reg <= index_k;
            int_l_reg <= index_l;
            int_v_reg <= value;
        end

        if (cmd.int_mul)
        begin
            pj_reg <= mul_small(pt, int_v_reg);
            pa_reg <= mul_small(25'(a_rd_b_reg), int_v_reg);
            pb_reg <= mul_small(25'(b_rd_b_reg), int_v_reg);
        end

        if (cmd.fin_mul)
        begin
            tk_reg    <= mul_small(ptc, t_rd_reg);
            tv_reg    <= mul_small(ptc, v_rd_reg);
            hp_j_reg  <= 49'(uj[55:32]) * 49'(ub_t);
            lp_j_reg  <= 57'(uj[31:0]) * 57'(ub_t);
            neg_j_reg <= j_eff[55] ^ ptc[24];
            hp_a_reg  <= 49'(uka[55:32]) * 49'(ub_a);
            lp_a_reg  <= 57'(uka[31:0]) * 57'(ub_a);
            neg_a_reg <= ka_eff[55] ^ a_rd_a_reg[23];
            hp_b_reg  <= 49'(ukb[55:32]) * 49'(ub_b);
            lp_b_reg  <= 57'(ukb[31:0]) * 57'(ub_b);
            neg_b_reg <= kb_eff[55] ^ b_rd_a_reg[23];
            f_reg     <= clamp32(58'(t_rd_reg) + 58'(v_rd_reg) + 58'(j_eff) - 58'(ka_eff));
        end

        if (cmd.fin_sum)
        begin
            qk_reg <= 64'(tk_reg);
            qv_reg <= 64'(tv_reg);
            qj_reg <= big_round(hp_j_reg, lp_j_reg, neg_j_reg);
            qa_reg <= big_round(hp_a_reg, lp_a_reg, neg_a_reg);
            qb_reg <= big_round(hp_b_reg, lp_b_reg, neg_b_reg);
        end

        if (cmd.fin_start)
        begin
            tr_k_reg <= '0;
            tr_v_reg <= '0;
            tr_j_reg <= '0;
            tr_a_reg <= '0;
            tr_b_reg <= '0;
        end
        else if (cmd.fin_acc)
        begin
            tr_k_reg <= sat64(65'(tr_k_reg) + 65'(qk_reg));
            tr_v_reg <= sat64(65'(tr_v_reg) + 65'(qv_reg));
            tr_j_reg <= sat64(65'(tr_j_reg) + 65'(qj_reg));
            tr_a_reg <= sat64(65'(tr_a_reg) + 65'(qa_reg));
            tr_b_reg <= sat64(65'(tr_b_reg) + 65'(qb_reg));
        end

        if (cmd.fin_acc)
        begin
            fock_element    <= f_reg;
            row             <= cmd.row;
            col             <= cmd.col;
            last            <= cmd.last;
            kinetic_energy  <= '0;
            energy_nuclear  <= '0;
            coulomb_energy  <= '0;
            exchange_energy <= '0;
            total_energy    <= '0;
        end

        if (cmd.fin_en1)
        begin
            ek_reg <= clamp48(65'(tr_k_reg));
            ev_reg <= clamp48(65'(tr_v_reg));
            ec_reg <= clamp48(65'(half_round(tr_j_reg)));
            ex_reg <= clamp48(-65'(half_round(tr_a_reg)) - 65'(half_round(tr_b_reg)));
        end

        if (cmd.fin_en2)
        begin
            kinetic_energy  <= ek_reg;
            energy_nuclear  <= ev_reg;
            coulomb_energy  <= ec_reg;
            exchange_energy <= ex_reg;
            total_energy    <= clamp48(65'(ek_reg) + 65'(ev_reg) + 65'(ec_reg) + 65'(ex_reg));
        end
    end

endmodule

`default_nettype wire

// File: rtl/fmb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fmb_ctrl import fmb_pkg::*; #(
    parameter int BASIS_MAX = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] kind,
    input  wire logic [2:0] index_i,
    input  wire logic [2:0] index_j,
    input  wire logic [2:0] index_k,
    input  wire logic [2:0] index_l,
    output logic            out_valid,
    input  wire logic       out_ready,
    output fmb_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INT_RD,
        S_INT_MUL,
        S_INT_ACC,
        S_FIN_RD,
        S_FIN_MUL,
        S_FIN_SUM,
        S_FIN_ACC,
        S_FIN_EN1,
        S_FIN_EN2,
        S_FIN_OUT
    } state_t;

    state_t     state_reg;
    logic [3:0] basis_size_reg;
    logic [2:0] row_reg, col_reg;
    logic       in_ready_reg, out_valid_reg;

    logic [3:0] n;
    logic       accept, int_ok, load_ok, is_last, row_end;

    always_comb
    begin
        if (basis_size_reg == 4'd0)
        begin
            n = 4'd1;
        end
        else if (32'(basis_size_reg) > BASIS_MAX)
        begin
            n = 4'(BASIS_MAX);
        end
        else
        begin
            n = basis_size_reg;
        end
    end

    assign accept  = in_valid && in_ready_reg;
    assign int_ok  = ({1'b0, index_i} < n) && ({1'b0, index_j} < n)
                  && ({1'b0, index_k} < n) && ({1'b0, index_l} < n);
    assign load_ok = (32'(index_i) < BASIS_MAX) && (32'(index_j) < BASIS_MAX);
    assign row_end = ({1'b0, col_reg} == n - 4'd1);
    assign is_last = row_end && ({1'b0, row_reg} == n - 4'd1);

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load_we   = accept && (kind inside {[KIND_ALPHA:KIND_NUCLEAR]}) && load_ok;
        cmd.capture   = accept;
        cmd.fin_start = accept && (kind == KIND_FINISH);
        cmd.fin_rd    = (state_reg == S_FIN_RD);
        cmd.int_mul   = (state_reg == S_INT_MUL);
        cmd.int_acc   = (state_reg == S_INT_ACC);
        cmd.fin_mul   = (state_reg == S_FIN_MUL);
        cmd.fin_sum   = (state_reg == S_FIN_SUM);
        cmd.fin_acc   = (state_reg == S_FIN_ACC);
        cmd.fin_en1   = (state_reg == S_FIN_EN1);
        cmd.fin_en2   = (state_reg == S_FIN_EN2);
        cmd.acc_clear = (state_reg == S_FIN_OUT) && out_ready && is_last;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.last      = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            basis_size_reg <= 4'd8;
            row_reg        <= '0;
            col_reg        <= '0;
            in_ready_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                basis_size_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == KIND_INTEGRAL && int_ok)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= S_INT_RD;
                    end
                    else if (accept && kind == KIND_FINISH)
                    begin
                        in_ready_reg <= 1'b0;
                        row_reg      <= '0;
                        col_reg      <= '0;
                        state_reg    <= S_FIN_RD;
                    end
                end
                S_INT_RD:  state_reg <= S_INT_MUL;
                S_INT_MUL: state_reg <= S_INT_ACC;
                S_INT_ACC:
                begin
                    in_ready_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_FIN_RD:  state_reg <= S_FIN_MUL;
                S_FIN_MUL: state_reg <= S_FIN_SUM;
                S_FIN_SUM: state_reg <= S_FIN_ACC;
                S_FIN_ACC:
                begin
                    if (is_last)
                    begin
                        state_reg <= S_FIN_EN1;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_FIN_OUT;
                    end
                end
                S_FIN_EN1: state_reg <= S_FIN_EN2;
                S_FIN_EN2:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_FIN_OUT;
                end
                S_FIN_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (is_last)
                        begin
                            in_ready_reg <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            if (row_end)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 3'd1;
                            end
                            else
                            begin
                                col_reg <= col_reg + 3'd1;
                            end
                            state_reg <= S_FIN_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/fock_matrix_build_unit.sv
// Hartree-Fock Fock matrix builder, Q8.16 fixed point. Load transactions
// (alpha and beta density, kinetic, nuclear attraction) write on acceptance
// and leave the input ready. An integral transaction keeps the block busy:
// read the density and accumulator memories, multiply and round, then
// read-modify-write the J, Ka and Kb accumulators through their single write
// port. A finish transaction emits n*n Fock elements in row-major order,
// each read, multiplied, summed and accumulated, plus any output stall; states EN1
// and EN2 form the energy traces before the last element; the accumulators
// clear as it leaves. Integrals must follow loading of the densities.
`timescale 1ns / 1ps
`default_nettype none

module fock_matrix_build_unit import fmb_pkg::*; #(
    parameter int BASIS_MAX = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [3:0]   cfg_wr_data,   // basis_size
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,  // index_i, index_j, index_k, index_l, value
    input  wire logic [2:0]   s_axis_tuser,  // kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // fock_element, row, col, kinetic, nuclear, coulomb, exchange and
    // total energy
    output logic [279:0]      m_axis_tdata,
    output logic              m_axis_tlast
);

    fmb_cmd_t           cmd;
    logic signed [31:0] fock_element;
    logic [2:0]         row, col;
    logic signed [47:0] e_kin, e_nuc, e_coul, e_exch, e_tot;

    fmb_ctrl #(.BASIS_MAX(BASIS_MAX)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .kind        (s_axis_tuser),
        .index_i     (s_axis_tdata[2:0]),
        .index_j     (s_axis_tdata[5:3]),
        .index_k     (s_axis_tdata[8:6]),
        .index_l     (s_axis_tdata[11:9]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .cmd         (cmd)
    );

    fmb_datapath #(.BASIS_MAX(BASIS_MAX)) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (s_axis_tuser),
        .index_i         (s_axis_tdata[2:0]),
        .index_j         (s_axis_tdata[5:3]),
        .index_k         (s_axis_tdata[8:6]),
        .index_l         (s_axis_tdata[11:9]),
        .value           (s_axis_tdata[35:12]),
        .fock_element    (fock_element),
        .row             (row),
        .col             (col),
        .last            (m_axis_tlast),
        .kinetic_energy  (e_kin),
        .energy_nuclear  (e_nuc),
        .coulomb_energy  (e_coul),
        .exchange_energy (e_exch),
        .total_energy    (e_tot)
    );

    assign m_axis_tdata = {2'b00, e_tot, e_exch, e_coul, e_nuc, e_kin, col, row, fock_element};

endmodule

`default_nettype wire

// File: tb/sv/fock_matrix_build_unit_tb.sv
`timescale 1ns / 1ps

module fock_matrix_build_unit_tb;
    import fmb_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int         N_MAX         = 8;
    localparam int         SETTLE_CYCLES = 16;

    typedef struct {
        logic [31:0] fock;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic [47:0] ek;
        logic [47:0] ev;
        logic [47:0] ec;
        logic [47:0] ex;
        logic [47:0] et;
    } fock_result_t;

    class fock_scoreboard;
        fock_result_t fock_q[$];
        int           errors;
        logic [3:0]   basis_size;
        longint       pa[N_MAX][N_MAX];
        longint       pb[N_MAX][N_MAX];
        longint       tk[N_MAX][N_MAX];
        longint       vn[N_MAX][N_MAX];
        longint       jc[N_MAX][N_MAX];
        longint       ka[N_MAX][N_MAX];
        longint       kb[N_MAX][N_MAX];

        function new();
            errors     = 0;
            basis_size = 4'd8;
            for (int r = 0; r < N_MAX; r++)
            begin
                for (int c = 0; c < N_MAX; c++)
                begin
                    pa[r][c] = 0; pb[r][c] = 0; tk[r][c] = 0; vn[r][c] = 0;
                    jc[r][c] = 0; ka[r][c] = 0; kb[r][c] = 0;
                end
            end
        endfunction

        function int side();
            if (basis_size < 1) return 1;
            if (basis_size > N_MAX) return N_MAX;
            return int'(basis_size);
        endfunction

        function longint clamp(longint x, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        function longint sadd(longint a, longint b);
            longint s;
            s = a + b;
            if (a > 0 && b > 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
            if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
            return s;
        endfunction

        // rounded Q.16 product, half away from zero, magnitude capped at 2^62
        function longint qmul(longint a, longint b);
            longint unsigned ua, ub, ah, al, hp, r;
            bit neg;
            ua  = (a < 0) ? longint'(-a) : a;
            ub  = (b < 0) ? longint'(-b) : b;
            ah  = ua >> 32;
            al  = ua & 64'hFFFF_FFFF;
            hp  = ah * ub;
            neg = (a < 0) != (b < 0);
            if (hp >= (64'd1 << 46))
            begin
                r = 64'd1 << 62;
            end
            else
            begin
                r = (hp << 16) + ((al * ub + 64'd32768) >> 16);
                if (r > (64'd1 << 62)) r = 64'd1 << 62;
            end
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint halve(longint x);
            longint unsigned ux, r;
            ux = (x < 0) ? longint'(-x) : x;
            r  = (ux >> 1) + (ux & 1);
            return (x < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void note_input(logic [2:0] kind, int i, int j, int k, int l,
                                 logic signed [23:0] value);
            int n;
            longint v, sk, sv, sj, sa, sb2, ek, ev, ec, ex, et, pt, f;
            fock_result_t e;
            n = side();
            v = longint'(value);
            case (kind)
                KIND_ALPHA:   pa[i][j] = v;
                KIND_BETA:    pb[i][j] = v;
                KIND_KINETIC: tk[i][j] = v;
                KIND_NUCLEAR: vn[i][j] = v;
                KIND_INTEGRAL:
                begin
                    if (i < n && j < n && k < n && l < n)
                    begin
                        pt = pa[k][l] + pb[k][l];
                        jc[i][j] = clamp(jc[i][j] + qmul(pt, v), 56);
                        ka[i][l] = clamp(ka[i][l] + qmul(pa[j][k], v), 56);
                        kb[i][l] = clamp(kb[i][l] + qmul(pb[j][k], v), 56);
                    end
                end
                KIND_FINISH:
                begin
                    sk = 0; sv = 0; sj = 0; sa = 0; sb2 = 0;
                    for (int r = 0; r < n; r++)
                    begin
                        for (int c = 0; c < n; c++)
                        begin
                            pt  = pa[c][r] + pb[c][r];
                            sk  = sadd(sk, qmul(tk[r][c], pt));
                            sv  = sadd(sv, qmul(vn[r][c], pt));
                            sj  = sadd(sj, qmul(jc[r][c], pt));
                            sa  = sadd(sa, qmul(ka[r][c], pa[c][r]));
                            sb2 = sadd(sb2, qmul(kb[r][c], pb[c][r]));
                        end
                    end
                    ek = clamp(sk, 48);
                    ev = clamp(sv, 48);
                    ec = clamp(halve(sj), 48);
                    ex = clamp(sadd(-halve(sa), -halve(sb2)), 48);
                    et = clamp(sadd(sadd(ek, ev), sadd(ec, ex)), 48);
                    for (int r = 0; r < n; r++)
                    begin
                        for (int c = 0; c < n; c++)
                        begin
                            f      = tk[r][c] + vn[r][c] + jc[r][c] - ka[r][c];
                            e.fock = 32'(clamp(f, 32));
                            e.row  = 3'(r);
                            e.col  = 3'(c);
                            e.last = (r == n - 1) && (c == n - 1);
                            e.ek   = e.last ? ek[47:0] : '0;
                            e.ev   = e.last ? ev[47:0] : '0;
                            e.ec   = e.last ? ec[47:0] : '0;
                            e.ex   = e.last ? ex[47:0] : '0;
                            e.et   = e.last ? et[47:0] : '0;
                            fock_q.push_back(e);
                        end
                    end
                    for (int r = 0; r < N_MAX; r++)
                    begin
                        for (int c = 0; c < N_MAX; c++)
                        begin
                            jc[r][c] = 0; ka[r][c] = 0; kb[r][c] = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [279:0] d, logic last);
            fock_result_t e;
            if (fock_q.size() == 0)
            begin
                report("unexpected transaction", 64'(d[37:32]), 64'd0);
                return;
            end
            e = fock_q.pop_front();
            if (d[31:0] !== e.fock) report("fock_element", 64'(d[31:0]), 64'(e.fock));
            if (d[34:32] !== e.row) report("row", 64'(d[34:32]), 64'(e.row));
            if (d[37:35] !== e.col) report("col", 64'(d[37:35]), 64'(e.col));
            if (last !== e.last) report("last", 64'(last), 64'(e.last));
            if (d[85:38] !== e.ek) report("kinetic energy", 64'(d[85:38]), 64'(e.ek));
            if (d[133:86] !== e.ev) report("energy_nuclear", 64'(d[133:86]), 64'(e.ev));
            if (d[181:134] !== e.ec) report("coulomb energy", 64'(d[181:134]), 64'(e.ec));
            if (d[229:182] !== e.ex) report("exchange energy", 64'(d[229:182]), 64'(e.ex));
            if (d[277:230] !== e.et) report("total energy", 64'(d[277:230]), 64'(e.et));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [3:0]   cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [279:0] m_axis_tdata;
    logic         m_axis_tlast;

    fock_scoreboard sb;
    bit             loaded[4][N_MAX][N_MAX];
    int             cur_side;
    bit             quiet;
    bit             hold_start;
    int             hold_cnt;
    int             stall_cnt;

    fock_matrix_build_unit #(.BASIS_MAX(N_MAX)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    initial
    begin
        #36_000_000;
        $display("fock_matrix_build_unit_tb: FAIL");
        $finish;
    end

    // result side: check, then choose next tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold_start)
            begin
                hold_cnt   = 400;
                hold_start = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (quiet)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 16);
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 131072)));
            3: return 24'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 1024)));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [2:0] kind, int i, int j, int k, int l, logic [23:0] v);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, v, 3'(l), 3'(k), 3'(j), 3'(i)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(kind, i, j, k, l, v);
        if (kind <= KIND_NUCLEAR) loaded[kind][i][j] = 1;
    endtask

    task automatic make_loaded(int m, int r, int c);
        if (!loaded[m][r][c]) send_item(3'(m), r, c, 0, 0, pick_value());
    endtask

    task automatic send_integral(int i, int j, int k, int l, logic [23:0] v);
        make_loaded(KIND_ALPHA, k, l);
        make_loaded(KIND_BETA, k, l);
        make_loaded(KIND_ALPHA, j, k);
        make_loaded(KIND_BETA, j, k);
        send_item(KIND_INTEGRAL, i, j, k, l, v);
    endtask

    task automatic send_finish();
        for (int m = 0; m < 4; m++)
            for (int r = 0; r < cur_side; r++)
                for (int c = 0; c < cur_side; c++)
                    make_loaded(m, r, c);
        send_item(KIND_FINISH, 0, 0, 0, 0, 24'd0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.fock_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(logic [3:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.basis_size = v;
        cur_side      = sb.side();
    endtask

    function automatic int pick_index();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_MAX - 1)
                                           : $urandom_range(0, cur_side - 1);
    endfunction

    initial
    begin
        logic [3:0] sizes[12];
        int sel;
        sizes         = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd4, 4'd7,
                          4'd2, 4'd6, 4'd8, 4'd3};
        clk           = 0;
        rst_n         = 0;
        cfg_wr_en     = 0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 0;
        quiet         = 0;
        hold_start    = 0;
        hold_cnt      = 0;
        stall_cnt     = 0;
        cur_side      = N_MAX;
        sb            = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: side 2, extreme values, out-of-side indices, spare kinds
        write_size(4'd2);
        send_item(KIND_ALPHA, 0, 0, 0, 0, 24'h7FFFFF);
        send_item(KIND_ALPHA, 0, 1, 0, 0, 24'h800000);
        send_item(KIND_ALPHA, 1, 0, 0, 0, 24'h010000);
        send_item(KIND_ALPHA, 1, 1, 0, 0, 24'hFF0000);
        send_item(KIND_BETA, 0, 0, 0, 0, 24'h800000);
        send_item(KIND_BETA, 0, 1, 0, 0, 24'h7FFFFF);
        send_item(KIND_BETA, 1, 0, 0, 0, 24'h000001);
        send_item(KIND_BETA, 1, 1, 0, 0, 24'hFFFFFF);
        send_item(KIND_KINETIC, 7, 7, 0, 0, 24'h123456);
        send_item(KIND_NUCLEAR, 7, 0, 0, 0, 24'h800000);
        send_integral(0, 0, 0, 0, 24'h7FFFFF);
        send_integral(1, 1, 1, 1, 24'h800000);
        send_integral(0, 1, 1, 0, 24'h7FFFFF);
        send_integral(1, 0, 0, 1, 24'h000001);
        send_integral(7, 0, 0, 0, 24'h7FFFFF);
        send_integral(0, 0, 0, 7, 24'h7FFFFF);
        send_item(KIND_SPARE_LO, 1, 1, 1, 1, 24'h7FFFFF);
        send_item(KIND_SPARE_HI, 0, 0, 0, 0, 24'h800000);
        for (int r = 0; r < 30; r++) send_integral(0, 0, 0, 0, 24'h7FFFFF);
        send_finish();
        send_finish();
        drain();

        for (int p = 0; p < 12; p++)
        begin
            quiet = (p == 11);
            write_size(sizes[p]);
            for (int t = 0; t < 14; t++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    send_integral(pick_index(), pick_index(), pick_index(), pick_index(),
                                  pick_value());
                else if (sel < 88)
                    send_item(3'($urandom_range(0, 3)), $urandom_range(0, N_MAX - 1),
                              $urandom_range(0, N_MAX - 1), $urandom_range(0, N_MAX - 1),
                              $urandom_range(0, N_MAX - 1), pick_value());
                else if (sel < 92)
                    send_item($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI,
                              $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
                else
                    send_finish();
            end
            send_finish();
            if (p == 4)
            begin
                // hold the result side off while integrals keep arriving
                hold_start = 1;
                for (int t = 0; t < 10; t++)
                    send_integral(pick_index(), pick_index(), pick_index(), pick_index(),
                                  pick_value());
                send_finish();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("fock_matrix_build_unit_tb: PASS");
        else
            $display("fock_matrix_build_unit_tb: FAIL");
        $finish;
    end

endmodule
